/* hw/rtl/tfp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfp_pkg
// Shared constants and types of the temporal fastest path engine.
// ----------------------------------------------------------------------------
package tfp_pkg;

	// Fixed field widths at the block boundary.
	localparam int VTX_BITS       = 6;
	localparam int PORT_TIME_BITS = 16;
	localparam int JOUR_OUT_BITS  = 17;
	localparam int DIST_BITS      = 20;

	// Distance codes: all ones means unreached, one below that is the saturation value.
	localparam logic [DIST_BITS-1:0] DIST_ALL = {DIST_BITS{1'b1}};
	localparam logic [DIST_BITS-1:0] DIST_SAT = {{(DIST_BITS-1){1'b1}}, 1'b0};

	// Configuration port.
	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_DATA_BITS = 32;
	// Register index, taken from byte address bit 2.
	localparam logic [0:0] REG_SOURCE_VERTEX = 1'b0;

	// Write strobes of the per-vertex tables.
	typedef struct packed {
		logic len_we;
		logic best_we;
	} vs_wr_t;

endpackage
`default_nettype wire

/* hw/rtl/tfp_tstore.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfp_tstore
// Triple store: start, arrival and distance of every list entry of every vertex.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tfp_tstore #(
	parameter int NUM_VERTICES = 64,
	parameter int LIST_DEPTH   = 16,
	parameter int TIME_BITS    = 16,
	localparam int DEPTH       = NUM_VERTICES * LIST_DEPTH,
	localparam int TAW         = $clog2(DEPTH)
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [TAW-1:0]                waddr,
	input  wire logic [TIME_BITS-1:0]          w_start,
	input  wire logic [TIME_BITS:0]            w_arr,
	input  wire logic [tfp_pkg::DIST_BITS-1:0] w_dist,
	input  wire logic [TAW-1:0]                raddr,
	output logic      [TIME_BITS-1:0]          r_start,
	output logic      [TIME_BITS:0]            r_arr,
	output logic      [tfp_pkg::DIST_BITS-1:0] r_dist
);
	import tfp_pkg::*;

	localparam int EW = TIME_BITS + (TIME_BITS + 1) + DIST_BITS;

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {w_start, w_arr, w_dist};
		end
		rd_q <= mem[raddr];
	end

	assign {r_start, r_arr, r_dist} = rd_q;

endmodule
`default_nettype wire

/* hw/rtl/tfp_vstore.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfp_vstore
// Per-vertex tables: list length and best journey/distance.
// Each entry has a valid bit; an entry never written reads as its reset value.
// ----------------------------------------------------------------------------
module tfp_vstore #(
	parameter int NUM_VERTICES = 64,
	parameter int LIST_DEPTH   = 16,
	parameter int TIME_BITS    = 16,
	localparam int VW          = $clog2(NUM_VERTICES),
	localparam int LENW        = $clog2(LIST_DEPTH + 1),
	localparam int BW          = TIME_BITS + 1 + tfp_pkg::DIST_BITS
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tfp_pkg::vs_wr_t wr,
	input  wire logic [VW-1:0]   len_waddr,
	input  wire logic [LENW-1:0] len_wdata,
	input  wire logic [VW-1:0]   len_raddr,
	output logic      [LENW-1:0] len_rdata,
	input  wire logic [VW-1:0]   best_waddr,
	input  wire logic [BW-1:0]   best_wdata,
	input  wire logic [VW-1:0]   best_raddr,
	output logic      [BW-1:0]   best_rdata
);
	import tfp_pkg::*;

	logic [LENW-1:0]         len_mem [NUM_VERTICES];
	logic [BW-1:0]           best_mem [NUM_VERTICES];
	logic [NUM_VERTICES-1:0] len_vld_q;
	logic [NUM_VERTICES-1:0] best_vld_q;
	logic [LENW-1:0]         len_rd_q;
	logic [BW-1:0]           best_rd_q;
	logic                    len_rv_q;
	logic                    best_rv_q;

	always_ff @(posedge clk) begin
		if (wr.len_we) begin
			len_mem[len_waddr] <= len_wdata;
		end
		if (wr.best_we) begin
			best_mem[best_waddr] <= best_wdata;
		end
		len_rd_q  <= len_mem[len_raddr];
		best_rd_q <= best_mem[best_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_vld_q  <= '0;
			best_vld_q <= '0;
			len_rv_q   <= 1'b0;
			best_rv_q  <= 1'b0;
		end else begin
			len_rv_q  <= len_vld_q[len_raddr];
			best_rv_q <= best_vld_q[best_raddr];
			if (wr.len_we) begin
				len_vld_q[len_waddr] <= 1'b1;
			end
			if (wr.best_we) begin
				best_vld_q[best_waddr] <= 1'b1;
			end
		end
	end

	assign len_rdata  = len_rv_q  ? len_rd_q  : '0;
	assign best_rdata = best_rv_q ? best_rd_q : '1;

endmodule
`default_nettype wire

/* hw/rtl/tfp_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfp_seq
// Sequencer: reads the vertex tables, scans the tail and head lists through
// the single triple store read port, compacts the head list, appends the new
// triple, updates the best values and registers the result.
// ----------------------------------------------------------------------------
module tfp_seq #(
	parameter int NUM_VERTICES = 64,
	parameter int LIST_DEPTH   = 16,
	parameter int TIME_BITS    = 16,
	localparam int VW          = $clog2(NUM_VERTICES),
	localparam int LENW        = $clog2(LIST_DEPTH + 1),
	localparam int AW          = TIME_BITS + 1,
	localparam int TAW         = $clog2(NUM_VERTICES * LIST_DEPTH),
	localparam int BW          = AW + tfp_pkg::DIST_BITS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [tfp_pkg::VTX_BITS-1:0]       source_vertex,
	input  wire logic                               cfg_wr,
	input  wire logic                               edge_valid,
	output logic                                    edge_stall,
	input  wire logic [tfp_pkg::VTX_BITS-1:0]       edge_from,
	input  wire logic [tfp_pkg::VTX_BITS-1:0]       edge_to,
	input  wire logic [tfp_pkg::PORT_TIME_BITS-1:0] edge_time,
	input  wire logic [tfp_pkg::PORT_TIME_BITS-1:0] edge_duration,
	output logic                                    result_valid,
	input  wire logic                               result_stall,
	output logic      [tfp_pkg::VTX_BITS-1:0]       target_vertex,
	output logic      [tfp_pkg::JOUR_OUT_BITS-1:0]  best_journey_out,
	output logic      [tfp_pkg::DIST_BITS-1:0]      best_travel_out,
	output logic                                    triple_accepted,
	output logic                                    list_full,
	output logic                                    t_we,
	output logic      [TAW-1:0]                     t_waddr,
	output logic      [TIME_BITS-1:0]               t_wstart,
	output logic      [AW-1:0]                      t_warr,
	output logic      [tfp_pkg::DIST_BITS-1:0]      t_wdist,
	output logic      [TAW-1:0]                     t_raddr,
	input  wire logic [TIME_BITS-1:0]               t_rstart,
	input  wire logic [AW-1:0]                      t_rarr,
	input  wire logic [tfp_pkg::DIST_BITS-1:0]      t_rdist,
	output tfp_pkg::vs_wr_t                         vs_wr,
	output logic      [VW-1:0]                      len_waddr,
	output logic      [LENW-1:0]                    len_wdata,
	output logic      [VW-1:0]                      len_raddr,
	input  wire logic [LENW-1:0]                    len_rdata,
	output logic      [VW-1:0]                      best_waddr,
	output logic      [BW-1:0]                      best_wdata,
	output logic      [VW-1:0]                      best_raddr,
	input  wire logic [BW-1:0]                      best_rdata
);
	import tfp_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD_LF, ST_RD_LT, ST_RD_BT, ST_LD_B,
		ST_SCAN_S, ST_PUSH_S, ST_SCAN_N, ST_SCAN_D, ST_DROP,
		ST_PUSH_T, ST_WB_F, ST_WB_T, ST_DONE
	} state_t;

	localparam logic [LENW-1:0] LEN_MAX = LENW'(LIST_DEPTH);

	function automatic logic [TAW-1:0] taddr(input logic [VW-1:0] v, input logic [LENW-1:0] i);
		return TAW'(TAW'(v) * TAW'(LIST_DEPTH) + TAW'(i));
	endfunction

	function automatic logic [DIST_BITS-1:0] sat_add(input logic [DIST_BITS-1:0] a,
			input logic [TIME_BITS-1:0] b);
		logic [DIST_BITS:0] s;
		s = {1'b0, a} + (DIST_BITS+1)'(b);
		if (s > {1'b0, DIST_SAT}) begin
			return DIST_SAT;
		end
		return s[DIST_BITS-1:0];
	endfunction

	state_t                  state_q;
	logic                    seed_pend_q;
	logic [VTX_BITS-1:0]     from_q, to_q;
	logic [TIME_BITS-1:0]    t_q, d_q;
	logic [LENW-1:0]         nf_q, nt_q, idx_q, w_q;
	logic                    pend_q;
	logic [AW-1:0]           bj_q;
	logic [DIST_BITS-1:0]    bt_q;
	logic                    acc_q, full_q, found_q, present_q, dom_q;
	logic [TIME_BITS-1:0]    ps_q;
	logic [AW-1:0]           pa_q;
	logic [DIST_BITS-1:0]    pd_q;
	logic [TIME_BITS-1:0]    cs_q;
	logic [AW-1:0]           ca_q;
	logic [DIST_BITS-1:0]    cd_q;
	logic                    ovld_q;
	logic [VTX_BITS-1:0]     o_to_q;
	logic [JOUR_OUT_BITS-1:0] o_bj_q;
	logic [DIST_BITS-1:0]    o_bt_q;
	logic                    o_acc_q, o_full_q;

	logic [VW-1:0]        fv, tv, sv;
	logic                 accept, in_range, src_in_range;
	logic                 scanning, scan_to, issue, scan_done;
	logic [LENW-1:0]      scan_n, nf_push;
	logic [AW-1:0]        t_ext, j_new;
	logic                 dom_hit, gone;

	assign fv = VW'(from_q);
	assign tv = VW'(to_q);
	assign sv = VW'(source_vertex);
	assign t_ext = AW'(t_q);
	assign src_in_range = 32'(source_vertex) < 32'(NUM_VERTICES);
	assign in_range = (32'(edge_from) < 32'(NUM_VERTICES)) &&
		(32'(edge_to) < 32'(NUM_VERTICES));

	assign edge_stall = (state_q != ST_IDLE) || seed_pend_q;
	assign accept = edge_valid && !edge_stall;

	assign scanning = (state_q == ST_SCAN_S) || (state_q == ST_SCAN_N) ||
		(state_q == ST_SCAN_D) || (state_q == ST_DROP);
	assign scan_to = (state_q == ST_SCAN_D) || (state_q == ST_DROP);
	assign scan_n = scan_to ? nt_q : nf_q;
	assign issue = scanning && (idx_q < scan_n);
	assign scan_done = !issue && !pend_q;
	assign t_raddr = taddr(scan_to ? tv : fv, idx_q);

	assign nf_push = (!present_q && (nf_q < LEN_MAX)) ? nf_q + 1'b1 : nf_q;

	// Dominance of the candidate by a stored entry, and the reverse test.
	always_comb begin
		if (cs_q == t_rstart) begin
			dom_hit = (t_rarr <= ca_q) && (t_rdist <= cd_q);
		end else if (ca_q == t_rarr) begin
			dom_hit = cs_q < t_rstart;
		end else begin
			dom_hit = (cs_q < t_rstart) && (ca_q > AW'(t_rstart));
		end
		gone = ((t_rstart == cs_q) && (ca_q <= t_rarr) && (cd_q <= t_rdist)) ||
			((ca_q == t_rarr) && (t_rstart < cs_q)) ||
			((t_rstart < cs_q) && (t_rarr > ca_q));
	end

	assign j_new = (ca_q >= AW'(cs_q)) ? ca_q - AW'(cs_q) : '0;

	always_comb begin
		t_we     = 1'b0;
		t_waddr  = taddr(tv, nt_q);
		t_wstart = cs_q;
		t_warr   = ca_q;
		t_wdist  = cd_q;
		case (state_q)
			ST_PUSH_S: begin
				t_we     = !present_q && (nf_q < LEN_MAX);
				t_waddr  = taddr(fv, nf_q);
				t_wstart = t_q;
				t_warr   = t_ext;
				t_wdist  = '0;
			end
			ST_PUSH_T: begin
				t_we = nt_q < LEN_MAX;
			end
			ST_DROP: begin
				t_we     = pend_q && !gone;
				t_waddr  = taddr(tv, w_q);
				t_wstart = t_rstart;
				t_warr   = t_rarr;
				t_wdist  = t_rdist;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		vs_wr      = '0;
		len_raddr  = (state_q == ST_RD_LF) ? fv : tv;
		best_raddr = tv;
		len_waddr  = (state_q == ST_WB_T) ? tv : fv;
		len_wdata  = (state_q == ST_WB_T) ? nt_q : nf_q;
		best_waddr = tv;
		best_wdata = {bj_q, bt_q};
		case (state_q)
			ST_IDLE: begin
				vs_wr.best_we = seed_pend_q && src_in_range;
				best_waddr    = sv;
				best_wdata    = '0;
			end
			ST_WB_F: begin
				vs_wr.len_we  = 1'b1;
				vs_wr.best_we = 1'b1;
			end
			ST_WB_T: begin
				vs_wr.len_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seed_pend_q <= 1'b1;
			from_q      <= '0;
			to_q        <= '0;
			t_q         <= '0;
			d_q         <= '0;
			nf_q        <= '0;
			nt_q        <= '0;
			idx_q       <= '0;
			w_q         <= '0;
			pend_q      <= 1'b0;
			bj_q        <= '1;
			bt_q        <= '1;
			acc_q       <= 1'b0;
			full_q      <= 1'b0;
			found_q     <= 1'b0;
			present_q   <= 1'b0;
			dom_q       <= 1'b0;
			ps_q        <= '0;
			pa_q        <= '0;
			pd_q        <= '0;
			cs_q        <= '0;
			ca_q        <= '0;
			cd_q        <= '0;
			ovld_q      <= 1'b0;
			o_to_q      <= '0;
			o_bj_q      <= '0;
			o_bt_q      <= '0;
			o_acc_q     <= 1'b0;
			o_full_q    <= 1'b0;
		end else begin
			if (cfg_wr) begin
				seed_pend_q <= 1'b1;
			end else if (state_q == ST_IDLE) begin
				seed_pend_q <= 1'b0;
			end
			if ((state_q == ST_DONE) && (!ovld_q || !result_stall)) begin
				ovld_q <= 1'b1;
			end else if (ovld_q && !result_stall) begin
				ovld_q <= 1'b0;
			end
			if (scanning) begin
				if (issue) begin
					idx_q <= idx_q + 1'b1;
				end
				pend_q <= issue;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						from_q  <= edge_from;
						to_q    <= edge_to;
						t_q     <= TIME_BITS'(edge_time);
						d_q     <= TIME_BITS'(edge_duration);
						bj_q    <= '1;
						bt_q    <= '1;
						acc_q   <= 1'b0;
						full_q  <= 1'b0;
						state_q <= in_range ? ST_RD_LF : ST_DONE;
					end
				end
				ST_RD_LF: begin
					state_q <= ST_RD_LT;
				end
				ST_RD_LT: begin
					nf_q    <= len_rdata;
					state_q <= ST_RD_BT;
				end
				ST_RD_BT: begin
					nt_q    <= len_rdata;
					state_q <= ST_LD_B;
				end
				ST_LD_B: begin
					{bj_q, bt_q} <= best_rdata;
					idx_q     <= '0;
					pend_q    <= 1'b0;
					found_q   <= 1'b0;
					present_q <= 1'b0;
					ps_q      <= t_q;
					pa_q      <= '0;
					pd_q      <= '0;
					state_q   <= (from_q == source_vertex) ? ST_SCAN_S : ST_SCAN_N;
				end
				ST_SCAN_S: begin
					if (pend_q) begin
						if ((t_rstart == t_q) && (t_rarr == t_ext) && (t_rdist == '0)) begin
							present_q <= 1'b1;
						end
						if (!found_q && (t_rarr == t_ext)) begin
							found_q <= 1'b1;
							ps_q    <= t_rstart;
							pd_q    <= t_rdist;
						end
					end
					if (scan_done) begin
						state_q <= ST_PUSH_S;
					end
				end
				ST_PUSH_S: begin
					if (!present_q && (nf_q >= LEN_MAX)) begin
						full_q <= 1'b1;
					end
					nf_q <= nf_push;
					if (from_q == to_q) begin
						nt_q <= nf_push;
					end
					cs_q    <= ps_q;
					ca_q    <= t_ext + AW'(d_q);
					cd_q    <= sat_add(pd_q, d_q);
					state_q <= ST_PUSH_T;
				end
				ST_SCAN_N: begin
					if (pend_q && (t_rarr <= t_ext) && (!found_q || (t_rarr > pa_q))) begin
						found_q <= 1'b1;
						pa_q    <= t_rarr;
						ps_q    <= t_rstart;
						pd_q    <= t_rdist;
					end
					if (scan_done) begin
						cs_q   <= ps_q;
						ca_q   <= t_ext + AW'(d_q);
						cd_q   <= sat_add(pd_q, d_q);
						idx_q  <= '0;
						dom_q  <= 1'b0;
						state_q <= found_q ? ST_SCAN_D : ST_DONE;
					end
				end
				ST_SCAN_D: begin
					if (pend_q && dom_hit) begin
						dom_q <= 1'b1;
					end
					if (scan_done) begin
						idx_q   <= '0;
						w_q     <= '0;
						state_q <= dom_q ? ST_DONE : ST_DROP;
					end
				end
				ST_DROP: begin
					if (pend_q && !gone) begin
						w_q <= w_q + 1'b1;
					end
					if (scan_done) begin
						nt_q    <= w_q;
						state_q <= ST_PUSH_T;
					end
				end
				ST_PUSH_T: begin
					if (nt_q < LEN_MAX) begin
						nt_q  <= nt_q + 1'b1;
						acc_q <= 1'b1;
					end else begin
						full_q <= 1'b1;
					end
					if (j_new < bj_q) begin
						bj_q <= j_new;
						bt_q <= cd_q;
					end else if ((j_new == bj_q) && (cd_q < bt_q)) begin
						bt_q <= cd_q;
					end
					state_q <= ST_WB_F;
				end
				ST_WB_F: begin
					state_q <= ST_WB_T;
				end
				ST_WB_T: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!ovld_q || !result_stall) begin
						o_to_q   <= to_q;
						o_bj_q   <= JOUR_OUT_BITS'(bj_q);
						o_bt_q   <= bt_q;
						o_acc_q  <= acc_q;
						o_full_q <= full_q;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid     = ovld_q;
	assign target_vertex    = o_to_q;
	assign best_journey_out = o_bj_q;
	assign best_travel_out  = o_bt_q;
	assign triple_accepted  = o_acc_q;
	assign list_full        = o_full_q;

	// Compaction writes always trail the read pointer of the same list.
	a_drop_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DROP && pend_q) |-> (w_q < idx_q))
		else $error("compaction write pointer overtook read pointer");

	a_drop_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(t_we && state_q == ST_DROP) |-> (t_waddr != t_raddr))
		else $error("compaction write hits the entry being read");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("accepted transaction did not start the sequencer");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH_T) |-> (nt_q <= LEN_MAX && nf_q <= LEN_MAX))
		else $error("list length beyond list depth");

endmodule
`default_nettype wire

/* hw/rtl/temporal_fastest_path_engine_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// temporal_fastest_path_engine_top
// One-pass fastest journey search over time-sorted timed edges, with an
// APB-style register for the source vertex.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  edge      in         edge_valid / edge_stall   edge_from, edge_to, edge_time,
//                                                 edge_duration
//  result    out        result_valid / result_stall target_vertex, best_journey_out,
//                                                 best_travel_out, triple_accepted,
//                                                 list_full
//  config    in         psel / penable / pready   paddr, pwrite, pwdata, prdata
//
//  An edge from the source vertex scans only the tail list; any other edge scans
//  the tail list and may then scan the head list twice (dominance test, then
//  compaction), all through the single read port of the triple store, so the
//  time an edge keeps the engine busy grows with the tail and head list lengths.
//  After reset, and after each write of source_vertex, the block seeds the source
//  vertex's best values (if source_vertex is in range) before it takes an edge.
//  No clearing pass: the per-vertex tables carry valid bits cleared by reset.
//  A finished result waits in the output register while the next edge is accepted;
//  the engine holds its last step until that register is free.
//
module temporal_fastest_path_engine_top #(
	parameter int NUM_VERTICES = 64,
	parameter int LIST_DEPTH   = 16,
	parameter int TIME_BITS    = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [tfp_pkg::CFG_ADDR_BITS-1:0]  paddr,
	input  wire logic [tfp_pkg::CFG_DATA_BITS-1:0]  pwdata,
	output logic      [tfp_pkg::CFG_DATA_BITS-1:0]  prdata,
	output logic                                    pready,
	input  wire logic                               edge_valid,
	output logic                                    edge_stall,
	input  wire logic [tfp_pkg::VTX_BITS-1:0]       edge_from,
	input  wire logic [tfp_pkg::VTX_BITS-1:0]       edge_to,
	input  wire logic [tfp_pkg::PORT_TIME_BITS-1:0] edge_time,
	input  wire logic [tfp_pkg::PORT_TIME_BITS-1:0] edge_duration,
	output logic                                    result_valid,
	input  wire logic                               result_stall,
	output logic      [tfp_pkg::VTX_BITS-1:0]       target_vertex,
	output logic      [tfp_pkg::JOUR_OUT_BITS-1:0]  best_journey_out,
	output logic      [tfp_pkg::DIST_BITS-1:0]      best_travel_out,
	output logic                                    triple_accepted,
	output logic                                    list_full
);
	import tfp_pkg::*;

	localparam int VW   = $clog2(NUM_VERTICES);
	localparam int LENW = $clog2(LIST_DEPTH + 1);
	localparam int AW   = TIME_BITS + 1;
	localparam int TAW  = $clog2(NUM_VERTICES * LIST_DEPTH);
	localparam int BW   = AW + DIST_BITS;

	// Configuration register. Bit 2 of the byte address selects the register;
	// writes beyond the register list are ignored.
	logic [VTX_BITS-1:0] source_q;
	logic                reg_hit;
	logic                cfg_wr;

	assign pready  = 1'b1;
	assign reg_hit = paddr[2] == REG_SOURCE_VERTEX;
	assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? CFG_DATA_BITS'(source_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q <= '0;
		end else if (cfg_wr) begin
			source_q <= pwdata[VTX_BITS-1:0];
		end
	end

	// Triple store and per-vertex table connections.
	logic                 t_we;
	logic [TAW-1:0]       t_waddr, t_raddr;
	logic [TIME_BITS-1:0] t_wstart, t_rstart;
	logic [AW-1:0]        t_warr, t_rarr;
	logic [DIST_BITS-1:0] t_wdist, t_rdist;
	vs_wr_t               vs_wr;
	logic [VW-1:0]        len_waddr, len_raddr, best_waddr, best_raddr;
	logic [LENW-1:0]      len_wdata, len_rdata;
	logic [BW-1:0]        best_wdata, best_rdata;

	tfp_tstore #(
		.NUM_VERTICES(NUM_VERTICES),
		.LIST_DEPTH  (LIST_DEPTH),
		.TIME_BITS   (TIME_BITS)
	) u_tstore (
		.clk    (clk),
		.we     (t_we),
		.waddr  (t_waddr),
		.w_start(t_wstart),
		.w_arr  (t_warr),
		.w_dist (t_wdist),
		.raddr  (t_raddr),
		.r_start(t_rstart),
		.r_arr  (t_rarr),
		.r_dist (t_rdist)
	);

	tfp_vstore #(
		.NUM_VERTICES(NUM_VERTICES),
		.LIST_DEPTH  (LIST_DEPTH),
		.TIME_BITS   (TIME_BITS)
	) u_vstore (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (vs_wr),
		.len_waddr (len_waddr),
		.len_wdata (len_wdata),
		.len_raddr (len_raddr),
		.len_rdata (len_rdata),
		.best_waddr(best_waddr),
		.best_wdata(best_wdata),
		.best_raddr(best_raddr),
		.best_rdata(best_rdata)
	);

	// The sequencer drives both stores and owns the output register.
	tfp_seq #(
		.NUM_VERTICES(NUM_VERTICES),
		.LIST_DEPTH  (LIST_DEPTH),
		.TIME_BITS   (TIME_BITS)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.source_vertex   (source_q),
		.cfg_wr          (cfg_wr),
		.edge_valid      (edge_valid),
		.edge_stall      (edge_stall),
		.edge_from       (edge_from),
		.edge_to         (edge_to),
		.edge_time       (edge_time),
		.edge_duration   (edge_duration),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.target_vertex   (target_vertex),
		.best_journey_out(best_journey_out),
		.best_travel_out (best_travel_out),
		.triple_accepted (triple_accepted),
		.list_full       (list_full),
		.t_we            (t_we),
		.t_waddr         (t_waddr),
		.t_wstart        (t_wstart),
		.t_warr          (t_warr),
		.t_wdist         (t_wdist),
		.t_raddr         (t_raddr),
		.t_rstart        (t_rstart),
		.t_rarr          (t_rarr),
		.t_rdist         (t_rdist),
		.vs_wr           (vs_wr),
		.len_waddr       (len_waddr),
		.len_wdata       (len_wdata),
		.len_raddr       (len_raddr),
		.len_rdata       (len_rdata),
		.best_waddr      (best_waddr),
		.best_wdata      (best_wdata),
		.best_raddr      (best_raddr),
		.best_rdata      (best_rdata)
	);

endmodule
`default_nettype wire
